// ----- rtl/ntpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// NTP control status client package
// Shared types, widths, codes and request header constants.
// ----------------------------------------------------------------------------
package ntpcs_pkg;

  localparam int HEADER_BYTES     = 12;
  localparam int MAX_DATA_DEFAULT = 468;
  localparam int POS_W            = 9;
  localparam int IDX_W            = $clog2(HEADER_BYTES);
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_REPLY   = 1'b1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] REQ_BYTE0 = 8'h1e;
  localparam logic [7:0] REQ_BYTE1 = 8'h01;

  localparam logic [3:0] VERD_SYNCED     = 4'd0;
  localparam logic [3:0] VERD_NONE       = 4'd1;
  localparam logic [3:0] VERD_SHORT      = 4'd2;
  localparam logic [3:0] VERD_VERSION    = 4'd3;
  localparam logic [3:0] VERD_MODE       = 4'd4;
  localparam logic [3:0] VERD_OPCODE     = 4'd5;
  localparam logic [3:0] VERD_NOT_RESP   = 4'd6;
  localparam logic [3:0] VERD_ERROR      = 4'd7;
  localparam logic [3:0] VERD_SEQUENCE   = 4'd8;
  localparam logic [3:0] VERD_LEAP_ALARM = 4'd9;
  localparam logic [3:0] VERD_ODD_COUNT  = 4'd10;
  localparam logic [3:0] VERD_TOO_LARGE  = 4'd11;

  localparam logic [2:0] NTP_VERSION    = 3'd3;
  localparam logic [2:0] NTP_MODE_CTRL  = 3'd6;
  localparam logic [4:0] OP_READ_STATUS = 5'd1;
  localparam logic [5:0] SRC_NTP        = 6'd6;
  localparam logic [2:0] SEL_SYNC       = 3'd5;
  localparam logic [2:0] SEL_SYSPEER    = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [15:0] seq;
    logic [3:0]  verdict;
    logic        src;
  } cmd_t;

endpackage

// ----- rtl/ntpcs_front.sv -----
// ----------------------------------------------------------------------------
// NTP control status client front end
// Accepts items, parses reply bytes and issues request or verdict commands.
// ----------------------------------------------------------------------------
module ntpcs_front import ntpcs_pkg::*; #(
  parameter int MAX_DATA_BYTES = MAX_DATA_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       func,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  output logic       cmd_push,
  output cmd_t       cmd
);

  localparam int PACKET_LIMIT = HEADER_BYTES + MAX_DATA_BYTES;

  logic [15:0]      seq, seq_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      hdr_bits, hdr_bits_next;
  logic [15:0]      reply_seq, reply_seq_next;
  logic [15:0]      sys_status, sys_status_next;
  logic [15:0]      data_offset, data_offset_next;
  logic [15:0]      data_count, data_count_next;
  logic [7:0]       peer_high, peer_high_next;
  logic             good_peer, good_peer_next;
  logic             store;
  logic [POS_W-1:0] dpos;
  logic [POS_W-1:0] peer_start;
  logic             peer_good;
  logic [16:0]      span;
  logic [3:0]       verd;
  logic             src;

  function automatic logic [15:0] put_byte(logic [15:0] w, logic odd, logic [7:0] b);
    logic [15:0] r;
    r = odd ? {w[15:8], b} : {b, w[7:0]};
    return r;
  endfunction

  always_comb begin
    store            = (pos < POS_W'(PACKET_LIMIT));
    dpos             = pos - POS_W'(HEADER_BYTES);
    peer_start       = dpos - POS_W'(3);
    peer_good        = ({7'd0, peer_start} < data_count) && peer_high[7] && peer_high[4] &&
                       (peer_high[2:0] == SEL_SYNC || peer_high[2:0] == SEL_SYSPEER);
    hdr_bits_next    = hdr_bits;
    reply_seq_next   = reply_seq;
    sys_status_next  = sys_status;
    data_offset_next = data_offset;
    data_count_next  = data_count;
    peer_high_next   = peer_high;
    good_peer_next   = good_peer;
    pos_next         = pos;
    if (store) begin
      pos_next = pos + POS_W'(1);
      if (pos < POS_W'(2)) begin
        hdr_bits_next = put_byte(hdr_bits, pos[0], rx_byte);
      end else if (pos < POS_W'(4)) begin
        reply_seq_next = put_byte(reply_seq, pos[0], rx_byte);
      end else if (pos < POS_W'(6)) begin
        sys_status_next = put_byte(sys_status, pos[0], rx_byte);
      end else if (pos < POS_W'(8)) begin
        pos_next = pos + POS_W'(1);
      end else if (pos < POS_W'(10)) begin
        data_offset_next = put_byte(data_offset, pos[0], rx_byte);
      end else if (pos < POS_W'(HEADER_BYTES)) begin
        data_count_next = put_byte(data_count, pos[0], rx_byte);
      end else if (dpos[1:0] == 2'd2) begin
        peer_high_next = rx_byte;
      end else if (dpos[1:0] == 2'd3) begin
        good_peer_next = good_peer | peer_good;
      end
    end
  end

  always_comb begin
    span = {1'b0, data_offset_next} + {1'b0, data_count_next};
    src  = 1'b0;
    if (pos_next < POS_W'(HEADER_BYTES)) begin
      verd = VERD_SHORT;
    end else if (hdr_bits_next[13:11] != NTP_VERSION) begin
      verd = VERD_VERSION;
    end else if (hdr_bits_next[10:8] != NTP_MODE_CTRL) begin
      verd = VERD_MODE;
    end else if (hdr_bits_next[4:0] != OP_READ_STATUS) begin
      verd = VERD_OPCODE;
    end else if (!hdr_bits_next[7]) begin
      verd = VERD_NOT_RESP;
    end else if (hdr_bits_next[6]) begin
      verd = VERD_ERROR;
    end else if (reply_seq_next != seq) begin
      verd = VERD_SEQUENCE;
    end else if (sys_status_next[15:14] == 2'b11) begin
      verd = VERD_LEAP_ALARM;
    end else begin
      src = (sys_status_next[13:8] != SRC_NTP);
      if (data_count_next[1:0] != 2'b00) begin
        verd = VERD_ODD_COUNT;
      end else if (span > 17'(MAX_DATA_BYTES)) begin
        verd = VERD_TOO_LARGE;
      end else begin
        verd = good_peer_next ? VERD_SYNCED : VERD_NONE;
      end
    end
  end

  assign seq_next = seq + 16'd1;

  always_comb begin
    cmd_push    = take && (func == FUNC_REQUEST || rx_last);
    cmd.kind    = (func == FUNC_REQUEST) ? KIND_REQUEST : KIND_VERDICT;
    cmd.seq     = seq_next;
    cmd.verdict = verd;
    cmd.src     = src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= 16'd1;
      pos         <= '0;
      hdr_bits    <= '0;
      reply_seq   <= '0;
      sys_status  <= '0;
      data_offset <= '0;
      data_count  <= '0;
      peer_high   <= '0;
      good_peer   <= 1'b0;
    end else if (take) begin
      if (func == FUNC_REQUEST) begin
        seq       <= seq_next;
        pos       <= '0;
        good_peer <= 1'b0;
      end else begin
        hdr_bits    <= hdr_bits_next;
        reply_seq   <= reply_seq_next;
        sys_status  <= sys_status_next;
        data_offset <= data_offset_next;
        data_count  <= data_count_next;
        if (rx_last) begin
          pos       <= '0;
          good_peer <= 1'b0;
          peer_high <= '0;
        end else begin
          pos       <= pos_next;
          good_peer <= good_peer_next;
          peer_high <= peer_high_next;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    take && func == FUNC_REQUEST |=> seq == $past(seq_next))
    else $error("sequence number did not advance on request");
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(PACKET_LIMIT))
    else $error("byte position past packet limit");
  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    cmd_push |=> pos == '0 && !good_peer)
    else $error("reply state not cleared after command");
`endif

endmodule

// ----- rtl/ntpcs_queue.sv -----
// ----------------------------------------------------------------------------
// NTP control status client command queue
// Short queue between front end and back end.
// ----------------------------------------------------------------------------
module ntpcs_queue import ntpcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

// ----- rtl/ntpcs_back.sv -----
// ----------------------------------------------------------------------------
// NTP control status client back end
// Expands commands into request byte beats or a verdict beat.
// ----------------------------------------------------------------------------
module ntpcs_back import ntpcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind,
  output logic [7:0] tx_byte,
  output logic       run_last,
  output logic [3:0] verdict,
  output logic       source_unusual
);

  logic             out_valid;
  logic [IDX_W-1:0] idx;
  logic             load;
  logic             take;
  logic             last_idx;
  logic [7:0]       req_byte;

  always_comb begin
    load     = !out_valid || pop;
    take     = load && !q_empty;
    last_idx = (idx == IDX_W'(HEADER_BYTES - 1));
    q_pop    = take && (q_head.kind == KIND_VERDICT || last_idx);
    case (idx)
      IDX_W'(0): req_byte = REQ_BYTE0;
      IDX_W'(1): req_byte = REQ_BYTE1;
      IDX_W'(2): req_byte = q_head.seq[15:8];
      IDX_W'(3): req_byte = q_head.seq[7:0];
      default:   req_byte = 8'd0;
    endcase
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (take) begin
        idx <= q_pop ? '0 : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind <= q_head.kind;
      if (q_head.kind == KIND_REQUEST) begin
        tx_byte        <= req_byte;
        run_last       <= last_idx;
        verdict        <= VERD_SYNCED;
        source_unusual <= 1'b0;
      end else begin
        tx_byte        <= 8'd0;
        run_last       <= 1'b1;
        verdict        <= q_head.verdict;
        source_unusual <= q_head.src;
      end
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(HEADER_BYTES - 1))
    else $error("header index out of range");
  a_verdict_run: assert property (@(posedge clk) disable iff (rst)
    take && q_head.kind == KIND_VERDICT |-> idx == '0)
    else $error("verdict taken in the middle of a request run");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> run_last && out_valid)
    else $error("command retired without a closing beat");
`endif

endmodule

// ----- rtl/ntp_control_status_client.sv -----
// ----------------------------------------------------------------------------
// NTP control status client
// Mode 6 read-status request builder and reply checker.
// ----------------------------------------------------------------------------
// Input channel (push/full): func 0 issues a request, func 1 carries one
// reply byte, rx_last marks the final byte of a datagram. One item is taken
// per cycle while full is low.
// Result channel (empty/pop): a request yields twelve byte beats (run_last
// on the twelfth); a final reply byte yields one verdict beat. Results are
// registered; beats leave one per cycle while pop is high. A request
// occupies the result side for twelve beats, so sustained input rate is
// bounded by the mix of requests and reply datagrams. The front end parses
// bytes at one per cycle while full is low; a four-entry command queue and
// the output register decouple it from the back end. When pop is held low
// the output register holds, the queue fills, then full rises.
// Reset clears the queue, the output register and all reply state, and
// sets the sequence number to one; the first request carries two.
// ----------------------------------------------------------------------------
module ntp_control_status_client import ntpcs_pkg::*; #(
  parameter int MAX_DATA_BYTES = MAX_DATA_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  output logic       empty,
  input  logic       pop,
  output logic       out_kind,
  output logic [7:0] tx_byte,
  output logic       run_last,
  output logic [3:0] verdict,
  output logic       source_unusual
);

  logic take;
  logic cmd_push;
  cmd_t cmd;
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  assign take = push && !full;

  ntpcs_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .func    (func),
    .rx_byte (rx_byte),
    .rx_last (rx_last),
    .cmd_push(cmd_push),
    .cmd     (cmd)
  );

  ntpcs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd),
    .full (full),
    .pop  (q_pop),
    .rdata(q_head),
    .empty(q_empty)
  );

  ntpcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_kind      (out_kind),
    .tx_byte       (tx_byte),
    .run_last      (run_last),
    .verdict       (verdict),
    .source_unusual(source_unusual)
  );

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// NTP control status client testbench
// Sends read-status requests and reply datagrams (well-formed, corrupted,
// cut short, abandoned, overlong and noise) through the push/full side and
// checks every result beat popped from the empty/pop side against an
// in-bench predictor. Sender and receiver idle at random in several phases,
// and the receiver holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ntpcs_pkg::*;

  localparam int RAND_ITEMS   = 260;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int RUN_LIMIT    = 200000;
  localparam int PACKET_BYTES = HEADER_BYTES + MAX_DATA_DEFAULT;

  localparam int FL_NONE    = 0;
  localparam int FL_VERSION = 1;
  localparam int FL_MODE    = 2;
  localparam int FL_OPCODE  = 3;
  localparam int FL_NO_RESP = 4;
  localparam int FL_ERROR   = 5;
  localparam int FL_SEQ     = 6;
  localparam int FL_LEAP    = 7;
  localparam int FL_ODD     = 8;
  localparam int FL_BIG     = 9;
  localparam int FL_SHORT   = 10;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic       last;
    logic [3:0] verd;
    logic       src;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       func = FUNC_REQUEST;
  logic [7:0] rx_byte = 8'h00;
  logic       rx_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_kind;
  logic [7:0] tx_byte;
  logic       run_last;
  logic [3:0] verdict;
  logic       source_unusual;

  rx_item_t items_todo[$];
  rx_item_t cur_item;
  beat_t    beats_due[$];
  logic [7:0] dgram[$];
  logic [15:0] gen_seq = 16'd1;
  int n_gen = 0;
  int n_acc = 0;
  int total_items = 1;
  int n_err = 0;
  int n_cyc = 0;
  logic hold_rx = 1'b0;

  // client state as the block should hold it
  logic [15:0] cl_seq = 16'd1;
  logic [8:0]  cl_pos = '0;
  logic [15:0] cl_hdr = '0;
  logic [15:0] cl_rsp_seq = '0;
  logic [15:0] cl_status = '0;
  logic [15:0] cl_off = '0;
  logic [15:0] cl_cnt = '0;
  logic [7:0]  cl_peer_hi = '0;
  logic        cl_good = 1'b0;

  ntp_control_status_client i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .rx_byte        (rx_byte),
    .rx_last        (rx_last),
    .empty          (empty),
    .pop            (pop),
    .out_kind       (out_kind),
    .tx_byte        (tx_byte),
    .run_last       (run_last),
    .verdict        (verdict),
    .source_unusual (source_unusual)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] load_half(logic [15:0] w, logic [8:0] p, logic [7:0] b);
    return p[0] ? {w[15:8], b} : {b, w[7:0]};
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int phase_now();
    return (n_acc * 4) / total_items;
  endfunction

  task automatic forecast_beats(input rx_item_t it);
    beat_t bt;
    int d;
    if (it.func == FUNC_REQUEST) begin
      cl_seq = cl_seq + 16'd1;
      cl_pos = '0;
      cl_good = 1'b0;
      for (int k = 0; k < HEADER_BYTES; k++) begin
        bt = '0;
        bt.kind = KIND_REQUEST;
        if (k == 0) bt.tx = REQ_BYTE0;
        else if (k == 1) bt.tx = REQ_BYTE1;
        else if (k == 2) bt.tx = cl_seq[15:8];
        else if (k == 3) bt.tx = cl_seq[7:0];
        bt.last = (k == HEADER_BYTES - 1);
        beats_due.push_back(bt);
      end
    end else begin
      if (int'(cl_pos) < PACKET_BYTES) begin
        if (cl_pos < 2) cl_hdr = load_half(cl_hdr, cl_pos, it.data);
        else if (cl_pos < 4) cl_rsp_seq = load_half(cl_rsp_seq, cl_pos, it.data);
        else if (cl_pos < 6) cl_status = load_half(cl_status, cl_pos, it.data);
        else if (cl_pos < 8) cl_hdr = cl_hdr;
        else if (cl_pos < 10) cl_off = load_half(cl_off, cl_pos, it.data);
        else if (cl_pos < HEADER_BYTES) cl_cnt = load_half(cl_cnt, cl_pos, it.data);
        else begin
          d = int'(cl_pos) - HEADER_BYTES;
          if (d % 4 == 2) cl_peer_hi = it.data;
          else if (d % 4 == 3 && (d - 3) < int'(cl_cnt) && cl_peer_hi[7] && cl_peer_hi[4] &&
                   (cl_peer_hi[2:0] == SEL_SYNC || cl_peer_hi[2:0] == SEL_SYSPEER))
            cl_good = 1'b1;
        end
        cl_pos = cl_pos + 9'd1;
      end
      if (it.last) begin
        bt = '0;
        bt.kind = KIND_VERDICT;
        bt.last = 1'b1;
        if (int'(cl_pos) < HEADER_BYTES) bt.verd = VERD_SHORT;
        else if (cl_hdr[13:11] != NTP_VERSION) bt.verd = VERD_VERSION;
        else if (cl_hdr[10:8] != NTP_MODE_CTRL) bt.verd = VERD_MODE;
        else if (cl_hdr[4:0] != OP_READ_STATUS) bt.verd = VERD_OPCODE;
        else if (!cl_hdr[7]) bt.verd = VERD_NOT_RESP;
        else if (cl_hdr[6]) bt.verd = VERD_ERROR;
        else if (cl_rsp_seq != cl_seq) bt.verd = VERD_SEQUENCE;
        else if (cl_status[15:14] == 2'b11) bt.verd = VERD_LEAP_ALARM;
        else begin
          bt.src = (cl_status[13:8] != SRC_NTP);
          if (cl_cnt[1:0] != 2'b00) bt.verd = VERD_ODD_COUNT;
          else if (int'(cl_off) + int'(cl_cnt) > MAX_DATA_DEFAULT) bt.verd = VERD_TOO_LARGE;
          else bt.verd = cl_good ? VERD_SYNCED : VERD_NONE;
        end
        beats_due.push_back(bt);
        cl_pos = '0;
        cl_good = 1'b0;
        cl_peer_hi = '0;
      end
    end
  endtask

  task automatic add_item(input logic f, input logic [7:0] b, input logic l);
    rx_item_t it;
    it.func = f;
    it.data = b;
    it.last = l;
    items_todo.push_back(it);
    n_gen++;
    if (f == FUNC_REQUEST) gen_seq = gen_seq + 16'd1;
  endtask

  task automatic add_request();
    add_item(FUNC_REQUEST, 8'($urandom), 1'($urandom));
  endtask

  task automatic queue_dgram(input bit with_last);
    for (int i = 0; i < dgram.size(); i++)
      add_item(FUNC_REPLY, dgram[i], with_last && i == dgram.size() - 1);
  endtask

  task automatic build_reply(input int flaw, input int n_peers, input bit messy);
    logic [1:0] li, leap;
    logic [2:0] ver, mode;
    logic [4:0] op;
    logic [5:0] src;
    logic rsp, err, mbit;
    logic [15:0] seq, off, cnt;
    logic [7:0] hi;
    int cut;
    li = 2'($urandom);
    mbit = 1'($urandom);
    ver = NTP_VERSION;
    mode = NTP_MODE_CTRL;
    op = OP_READ_STATUS;
    rsp = 1'b1;
    err = 1'b0;
    seq = gen_seq;
    leap = 2'($urandom_range(0, 2));
    src = roll(30) ? 6'($urandom) : SRC_NTP;
    cnt = 16'(4 * n_peers);
    off = 16'($urandom_range(0, MAX_DATA_DEFAULT - int'(cnt)));
    if (roll(20)) off = 16'(MAX_DATA_DEFAULT - int'(cnt));
    case (flaw)
      FL_VERSION: while (ver == NTP_VERSION) ver = 3'($urandom);
      FL_MODE: while (mode == NTP_MODE_CTRL) mode = 3'($urandom);
      FL_OPCODE: while (op == OP_READ_STATUS) op = 5'($urandom);
      FL_NO_RESP: rsp = 1'b0;
      FL_ERROR: err = 1'b1;
      FL_SEQ: seq = gen_seq ^ (16'd1 << $urandom_range(0, 15));
      FL_LEAP: leap = 2'b11;
      FL_ODD: cnt = cnt + 16'($urandom_range(1, 3));
      FL_BIG: begin
        if (roll(50)) begin
          off = 16'(MAX_DATA_DEFAULT + 1 - int'(cnt) + $urandom_range(0, 40));
        end else begin
          cnt = 16'($urandom) & 16'hfffc;
          off = 16'($urandom);
        end
      end
      default: ;
    endcase
    dgram.delete();
    dgram.push_back({li, ver, mode});
    dgram.push_back({rsp, err, mbit, op});
    dgram.push_back(seq[15:8]);
    dgram.push_back(seq[7:0]);
    dgram.push_back({leap, src});
    dgram.push_back(8'($urandom));
    dgram.push_back(8'($urandom));
    dgram.push_back(8'($urandom));
    dgram.push_back(off[15:8]);
    dgram.push_back(off[7:0]);
    dgram.push_back(cnt[15:8]);
    dgram.push_back(cnt[7:0]);
    for (int p = 0; p < n_peers; p++) begin
      hi = roll(50) ? {1'b1, 2'($urandom), 1'b1, 1'($urandom), roll(50) ? SEL_SYNC : SEL_SYSPEER}
                    : 8'($urandom);
      dgram.push_back(8'($urandom));
      dgram.push_back(8'($urandom));
      dgram.push_back(hi);
      dgram.push_back(8'($urandom));
    end
    if (messy) begin
      case ($urandom_range(0, 3))
        1: begin
          dgram.push_back(8'($urandom));
          dgram.push_back(8'($urandom));
          dgram.push_back({1'b1, 2'b00, 1'b1, 1'b0, SEL_SYSPEER});
          dgram.push_back(8'($urandom));
        end
        2: if (n_peers > 0) repeat ($urandom_range(1, 3)) void'(dgram.pop_back());
        3: if (flaw == FL_NONE) begin
          dgram[10] = 8'($urandom_range(0, 1));
          dgram[11] = 8'(4 * $urandom_range(n_peers + 1, n_peers + 8));
        end
        default: ;
      endcase
    end
    if (flaw == FL_SHORT) begin
      cut = $urandom_range(1, HEADER_BYTES - 1);
      while (dgram.size() > cut) void'(dgram.pop_back());
    end
  endtask

  // stimulus, then wait for the last beat
  initial begin
    int pick, n_start, n_big;
    bit big_done;
    big_done = 1'b0;

    add_item(FUNC_REQUEST, 8'hff, 1'b1);
    build_reply(FL_NONE, 2, 1'b0);
    dgram[14] = {1'b1, 2'b00, 1'b1, 1'b0, SEL_SYNC};
    dgram[18] = {1'b1, 2'b11, 1'b1, 1'b1, SEL_SYSPEER};
    queue_dgram(1'b1);
    add_item(FUNC_REPLY, 8'h00, 1'b1);
    add_item(FUNC_REPLY, 8'hff, 1'b1);

    n_start = n_gen;
    while (n_gen < n_start + RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!big_done && n_gen >= n_start + RAND_ITEMS / 2) begin
        // overlong datagram: bytes past the packet limit are dropped
        build_reply(FL_NONE, 0, 1'b0);
        dgram[4] = {2'b00, SRC_NTP};
        dgram[8] = 8'h00;
        dgram[9] = 8'h00;
        dgram[10] = 8'(MAX_DATA_DEFAULT >> 8);
        dgram[11] = 8'(MAX_DATA_DEFAULT);
        for (int d = 0; d < MAX_DATA_DEFAULT + 4; d++)
          dgram.push_back(d == MAX_DATA_DEFAULT - 2 ? {1'b1, 2'b00, 1'b1, 1'b0, SEL_SYNC}
                                                    : 8'h00);
        n_big = dgram.size();
        queue_dgram(1'b1);
        n_gen -= n_big;
        big_done = 1'b1;
      end else if (pick < 15) begin
        add_request();
      end else if (pick < 80) begin
        build_reply(roll(45) ? FL_NONE : $urandom_range(FL_VERSION, FL_SHORT),
                    $urandom_range(0, 4), 1'b1);
        queue_dgram(1'b1);
      end else if (pick < 90) begin
        build_reply(FL_NONE, $urandom_range(0, 3), 1'b0);
        while (dgram.size() > 1 && roll(85)) void'(dgram.pop_back());
        queue_dgram(1'b0);
        add_request();
      end else begin
        dgram.delete();
        repeat ($urandom_range(1, 16)) dgram.push_back(8'($urandom));
        if (roll(70)) begin
          queue_dgram(1'b1);
        end else begin
          queue_dgram(1'b0);
          add_request();
        end
      end
    end
    total_items = items_todo.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (n_acc < total_items) @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("[ntp_control_status_client] OK");
    end else begin
      $display("[ntp_control_status_client] ERROR");
    end
    $finish;
  end

  // long receiver hold-off so the queue fills and full rises
  initial begin
    wait (n_acc >= 40);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    int idle_pct;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        forecast_beats(cur_item);
        n_acc++;
      end
      if (!push || !full) begin
        case (phase_now())
          1: idle_pct = 81;
          3: idle_pct = 11;
          default: idle_pct = 0;
        endcase
        if (items_todo.size() != 0 && !roll(idle_pct)) begin
          cur_item = items_todo.pop_front();
          push <= 1'b1;
          func <= cur_item.func;
          rx_byte <= cur_item.data;
          rx_last <= cur_item.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    beat_t want;
    int stall_pct;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (beats_due.size() == 0) begin
          $error("unexpected beat: out_kind %0d tx_byte %0h verdict %0d",
                 out_kind, tx_byte, verdict);
          n_err++;
        end else begin
          want = beats_due.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            n_err++;
          end
          if (tx_byte !== want.tx) begin
            $error("tx_byte: expected %0h, got %0h", want.tx, tx_byte);
            n_err++;
          end
          if (run_last !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, run_last);
            n_err++;
          end
          if (verdict !== want.verd) begin
            $error("verdict: expected %0d, got %0d", want.verd, verdict);
            n_err++;
          end
          if (source_unusual !== want.src) begin
            $error("source_unusual: expected %0d, got %0d", want.src, source_unusual);
            n_err++;
          end
        end
      end
      case (phase_now())
        2: stall_pct = 81;
        3: stall_pct = 11;
        default: stall_pct = 0;
      endcase
      pop <= !hold_rx && !roll(stall_pct);
    end
  end

  always @(posedge clk) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc >= RUN_LIMIT) begin
      $display("[ntp_control_status_client] ERROR");
      $finish;
    end
  end

endmodule
